// ===== design/gts_pkg.sv =====
// Shared types, constants and helpers of the grouped time statistics block.
package gts_pkg;

   // Default configuration of the block.
   localparam int DEFAULT_TABLE_DEPTH = 64;
   localparam int DEFAULT_TIME_BITS   = 32;
   localparam int DEFAULT_SUM_BITS    = 48;

   // Fixed widths of the request and result fields.
   localparam int KEY_W   = 32;
   localparam int OUT_W   = 48;
   localparam int COUNT_W = 7;
   localparam int WIDE_W  = 128;
   localparam int ROOT_W  = 64;

   // Request kinds.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [15:0] proc_id;
      logic [15:0] thread_id;
      logic [31:0] time_us;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] unit_count;
      logic [OUT_W-1:0]   mean_time;
      logic [OUT_W-1:0]   std_dev;
      logic [OUT_W-1:0]   max_time;
      logic [OUT_W-1:0]   min_time;
      logic               dropped_flag;
   } rsp_type;

   // Operations of the shared divide and square root unit.
   typedef enum logic {
      OP_DIV  = 1'b0,
      OP_SQRT = 1'b1
   } arith_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_READ,
      ST_CMP,
      ST_INSERT,
      ST_P1_READ,
      ST_P1_ACC,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_P2_READ,
      ST_P2_DIFF,
      ST_P2_MUL,
      ST_VAR_GO,
      ST_VAR_WAIT,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         capture;
      logic         idx_clr;
      logic         idx_inc;
      logic         wr_update;
      logic         wr_insert;
      logic         acc_step;
      logic         mean_load;
      logic         sq_clr;
      logic         diff_load;
      logic         mul_step;
      logic         arith_start;
      arith_op_type arith_op;
      logic         arith_var;
      logic         dev_load;
      logic         out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic kind;
      logic t_zero;
      logic used_zero;
      logic used_one;
      logic hit;
      logic idx_last;
      logic mul_last;
      logic arith_done;
      logic rsp_busy;
   } status_type;

   // Saturate a statistic to the result field width.
   function automatic logic [OUT_W-1:0] clamp_out(input logic [63:0] v);
      logic [63:0] lim;
      lim = {{(64-OUT_W){1'b0}}, {OUT_W{1'b1}}};
      return (v > lim) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
   endfunction

endpackage

// ===== design/gts_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module gts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gts_arith.sv =====
// Shared iterative unit: restoring division by the unit count and integer square root.
module gts_arith #(
   parameter int TABLE_DEPTH = gts_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  gts_pkg::arith_op_type          op,
   input  logic [gts_pkg::WIDE_W-1:0]     operand,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0] divisor,
   output logic                           done,
   output logic [gts_pkg::WIDE_W-1:0]     quotient,
   output logic [gts_pkg::ROOT_W-1:0]     root
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int REM_W = gts_pkg::ROOT_W + 3;
   localparam logic [6:0] DIV_LAST  = 7'(gts_pkg::WIDE_W - 1);
   localparam logic [6:0] SQRT_LAST = 7'(gts_pkg::ROOT_W - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   gts_pkg::arith_op_type         op_ff, op_in;
   logic [6:0]                    cnt_ff, cnt_in;
   logic [gts_pkg::WIDE_W-1:0]    acc_ff, acc_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [gts_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic [CNT_W-1:0]              div_ff, div_in;

   logic [CNT_W:0]   cand;
   logic             qbit;
   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic             last;

   // One quotient bit or one root bit per cycle.
   always_comb begin
      cand   = {rem_ff[CNT_W-1:0], acc_ff[gts_pkg::WIDE_W-1]};
      qbit   = (cand >= {1'b0, div_ff});
      rem_sh = {rem_ff[REM_W-3:0], acc_ff[gts_pkg::WIDE_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      last   = (cnt_ff == ((op_ff == gts_pkg::OP_DIV) ? DIV_LAST : SQRT_LAST));

      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      div_in  = div_ff;

      if (start) begin
         busy_in = 1'b1;
         op_in   = op;
         cnt_in  = '0;
         acc_in  = operand;
         rem_in  = '0;
         root_in = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 7'd1;
         if (op_ff == gts_pkg::OP_DIV) begin
            acc_in = {acc_ff[gts_pkg::WIDE_W-2:0], qbit};
            if (qbit) begin
               rem_in = REM_W'(cand - {1'b0, div_ff});
            end else begin
               rem_in = REM_W'(cand);
            end
         end else begin
            acc_in = {acc_ff[gts_pkg::WIDE_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[gts_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[gts_pkg::ROOT_W-2:0], 1'b0};
            end
         end
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = acc_ff;
   assign root     = root_ff;

endmodule

// ===== design/gts_dp.sv =====
// Datapath: unit table, accumulators, squaring, arithmetic unit and result register.
module gts_dp #(
   parameter int TABLE_DEPTH = gts_pkg::DEFAULT_TABLE_DEPTH,
   parameter int TIME_BITS   = gts_pkg::DEFAULT_TIME_BITS,
   parameter int SUM_BITS    = gts_pkg::DEFAULT_SUM_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gts_pkg::req_type     req_data,
   input  gts_pkg::cmd_type     cmd,
   output gts_pkg::status_type  status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output gts_pkg::rsp_type     rsp_data
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int AW     = ((SUM_BITS > TIME_BITS) ? SUM_BITS : TIME_BITS) + 1;
   localparam int TOT_W  = SUM_BITS + CNT_W;
   localparam int RAM_W  = gts_pkg::KEY_W + SUM_BITS;
   localparam int WW     = gts_pkg::WIDE_W;
   localparam logic [63:0]       TIME_MAX  = {64{1'b1}} >> (64 - TIME_BITS);
   localparam logic [AW-1:0]     SUM_MAX_A = AW'({SUM_BITS{1'b1}});
   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

   // Captured request.
   logic                        kind_ff, kind_in;
   logic [gts_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [TIME_BITS-1:0]        t_ff, t_in;

   // Table bookkeeping.
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              drop_ff, drop_in;

   // Statistics registers.
   logic [TOT_W-1:0]     tot_ff, tot_in;
   logic [SUM_BITS-1:0]  mx_ff, mx_in;
   logic [SUM_BITS-1:0]  mn_ff, mn_in;
   logic [SUM_BITS-1:0]  mean_ff, mean_in;
   logic [WW-1:0]        sq_ff, sq_in;
   logic [63:0]          d_ff, d_in;
   logic [2:0]           mul_cnt_ff, mul_cnt_in;
   logic [63:0]          prod_ff, prod_in;
   logic [1:0]           sh_ff, sh_in;
   logic [63:0]          dev_ff, dev_in;

   // Result register.
   gts_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [63:0]         t_wide;
   logic [RAM_W-1:0]    rd_data;
   logic [gts_pkg::KEY_W-1:0] rd_key;
   logic [SUM_BITS-1:0] rd_sum;
   logic [AW-1:0]       upd_a;
   logic [SUM_BITS-1:0] upd_sum;
   logic [SUM_BITS-1:0] ins_sum;
   logic                full;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [RAM_W-1:0]    wr_data;
   logic [31:0]         mul_a, mul_b;
   logic [WW-1:0]       prod_sh;
   logic [WW:0]         sq_sum;
   logic [WW-1:0]       arith_operand;
   logic                arith_done;
   logic [WW-1:0]       quotient;
   logic [gts_pkg::ROOT_W-1:0] root;

   gts_ram #(
      .WIDTH (RAM_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   gts_arith #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_arith (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.arith_start),
      .op       (cmd.arith_op),
      .operand  (arith_operand),
      .divisor  (used_ff),
      .done     (arith_done),
      .quotient (quotient),
      .root     (root)
   );

   // Table entry fields and the saturating sum update.
   always_comb begin
      rd_key  = rd_data[SUM_BITS +: gts_pkg::KEY_W];
      rd_sum  = rd_data[SUM_BITS-1:0];
      upd_a   = AW'(rd_sum) + AW'(t_ff);
      upd_sum = (upd_a > SUM_MAX_A) ? SUM_MAX : upd_a[SUM_BITS-1:0];
      ins_sum = (AW'(t_ff) > SUM_MAX_A) ? SUM_MAX : SUM_BITS'(t_ff);
      full    = (used_ff == CNT_W'(TABLE_DEPTH));
      wr_en   = cmd.wr_update | (cmd.wr_insert & ~full);
      wr_addr = cmd.wr_update ? idx_ff : used_ff[ADDR_W-1:0];
      wr_data = {key_ff, (cmd.wr_update ? upd_sum : ins_sum)};
   end

   // Squaring in four 32 by 32 partial products.
   always_comb begin
      mul_a   = mul_cnt_ff[1] ? d_ff[63:32] : d_ff[31:0];
      mul_b   = mul_cnt_ff[0] ? d_ff[63:32] : d_ff[31:0];
      prod_in = {32'd0, mul_a} * {32'd0, mul_b};
      sh_in   = {1'b0, mul_cnt_ff[1]} + {1'b0, mul_cnt_ff[0]};
      prod_sh = WW'(prod_ff) << {sh_ff, 5'b00000};
      sq_sum  = {1'b0, sq_ff} + {1'b0, prod_sh};
   end

   always_comb begin
      if (cmd.arith_op == gts_pkg::OP_SQRT) begin
         arith_operand = quotient;
      end else if (cmd.arith_var) begin
         arith_operand = sq_ff;
      end else begin
         arith_operand = WW'(tot_ff);
      end
   end

   // Next values of the datapath registers.
   always_comb begin
      t_wide = {32'd0, req_data.time_us};
      if (t_wide > TIME_MAX) begin
         t_wide = TIME_MAX;
      end

      kind_in    = kind_ff;
      key_in     = key_ff;
      t_in       = t_ff;
      used_in    = used_ff;
      idx_in     = idx_ff;
      drop_in    = drop_ff;
      tot_in     = tot_ff;
      mx_in      = mx_ff;
      mn_in      = mn_ff;
      mean_in    = mean_ff;
      sq_in      = sq_ff;
      d_in       = d_ff;
      mul_cnt_in = mul_cnt_ff;
      dev_in     = dev_ff;

      if (cmd.capture) begin
         kind_in = req_data.kind;
         key_in  = {req_data.proc_id, req_data.thread_id};
         t_in    = t_wide[TIME_BITS-1:0];
         tot_in  = '0;
         mx_in   = '0;
         mn_in   = SUM_MAX;
         mean_in = '0;
         dev_in  = '0;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + ADDR_W'(1);
      end
      if (cmd.wr_insert) begin
         if (full) begin
            drop_in = 1'b1;
         end else begin
            used_in = used_ff + CNT_W'(1);
         end
      end
      if (cmd.out_load) begin
         used_in = '0;
      end
      if (cmd.acc_step) begin
         tot_in = tot_ff + TOT_W'(rd_sum);
         if (rd_sum > mx_ff) begin
            mx_in = rd_sum;
         end
         if (rd_sum < mn_ff) begin
            mn_in = rd_sum;
         end
      end
      if (cmd.mean_load) begin
         mean_in = quotient[SUM_BITS-1:0];
      end
      if (cmd.sq_clr) begin
         sq_in = '0;
      end
      if (cmd.diff_load) begin
         d_in       = 64'((rd_sum >= mean_ff) ? (rd_sum - mean_ff) : (mean_ff - rd_sum));
         mul_cnt_in = '0;
      end
      if (cmd.mul_step) begin
         mul_cnt_in = mul_cnt_ff + 3'd1;
         if (mul_cnt_ff != 3'd0) begin
            sq_in = sq_sum[WW] ? {WW{1'b1}} : sq_sum[WW-1:0];
         end
      end
      if (cmd.dev_load) begin
         dev_in = root;
      end
   end

   // Result assembly and output register.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.out_load) begin
         rsp_valid_in        = 1'b1;
         rsp_in.unit_count   = (32'(used_ff) > 32'd127) ? 7'd127 : 7'(used_ff);
         rsp_in.mean_time    = gts_pkg::clamp_out(64'(mean_ff));
         rsp_in.std_dev      = gts_pkg::clamp_out(dev_ff);
         rsp_in.max_time     = gts_pkg::clamp_out(64'(mx_ff));
         rsp_in.min_time     = (used_ff == '0) ? {gts_pkg::OUT_W{1'b1}}
                                               : gts_pkg::clamp_out(64'(mn_ff));
         rsp_in.dropped_flag = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff    <= kind_in;
      key_ff     <= key_in;
      t_ff       <= t_in;
      idx_ff     <= idx_in;
      tot_ff     <= tot_in;
      mx_ff      <= mx_in;
      mn_ff      <= mn_in;
      mean_ff    <= mean_in;
      sq_ff      <= sq_in;
      d_ff       <= d_in;
      mul_cnt_ff <= mul_cnt_in;
      prod_ff    <= (cmd.mul_step && mul_cnt_ff < 3'd4) ? prod_in : prod_ff;
      sh_ff      <= (cmd.mul_step && mul_cnt_ff < 3'd4) ? sh_in : sh_ff;
      dev_ff     <= dev_in;
      rsp_ff     <= rsp_in;
   end

   // Status toward the controller.
   always_comb begin
      status.kind       = kind_ff;
      status.t_zero     = (t_ff == '0);
      status.used_zero  = (used_ff == '0);
      status.used_one   = (used_ff == CNT_W'(1));
      status.hit        = (rd_key == key_ff);
      status.idx_last   = (CNT_W'(idx_ff) == (used_ff - CNT_W'(1)));
      status.mul_last   = (mul_cnt_ff == 3'd4);
      status.arith_done = arith_done;
      status.rsp_busy   = rsp_valid_ff & ~rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/gts_ctrl.sv =====
// Controller state machine that sequences searches, inserts and the finish pass.
module gts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  gts_pkg::status_type status,
   output gts_pkg::cmd_type    cmd
);

   gts_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.arith_op  = gts_pkg::OP_DIV;
      req_ready     = 1'b0;
      unique case (state_ff)
         gts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = gts_pkg::ST_DISPATCH;
            end
         end
         gts_pkg::ST_DISPATCH: begin
            if (status.kind == gts_pkg::KIND_SAMPLE) begin
               if (status.t_zero) begin
                  state_in = gts_pkg::ST_IDLE;
               end else if (status.used_zero) begin
                  state_in = gts_pkg::ST_INSERT;
               end else begin
                  state_in = gts_pkg::ST_READ;
               end
            end else if (status.used_zero) begin
               state_in = gts_pkg::ST_OUT;
            end else begin
               state_in = gts_pkg::ST_P1_READ;
            end
         end
         gts_pkg::ST_READ: begin
            state_in = gts_pkg::ST_CMP;
         end
         gts_pkg::ST_CMP: begin
            if (status.hit) begin
               cmd.wr_update = 1'b1;
               state_in      = gts_pkg::ST_IDLE;
            end else if (status.idx_last) begin
               state_in = gts_pkg::ST_INSERT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = gts_pkg::ST_READ;
            end
         end
         gts_pkg::ST_INSERT: begin
            cmd.wr_insert = 1'b1;
            state_in      = gts_pkg::ST_IDLE;
         end
         gts_pkg::ST_P1_READ: begin
            state_in = gts_pkg::ST_P1_ACC;
         end
         gts_pkg::ST_P1_ACC: begin
            cmd.acc_step = 1'b1;
            if (status.idx_last) begin
               state_in = gts_pkg::ST_MEAN_GO;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = gts_pkg::ST_P1_READ;
            end
         end
         gts_pkg::ST_MEAN_GO: begin
            cmd.arith_start = 1'b1;
            state_in        = gts_pkg::ST_MEAN_WAIT;
         end
         gts_pkg::ST_MEAN_WAIT: begin
            if (status.arith_done) begin
               cmd.mean_load = 1'b1;
               if (status.used_one) begin
                  state_in = gts_pkg::ST_OUT;
               end else begin
                  cmd.idx_clr = 1'b1;
                  cmd.sq_clr  = 1'b1;
                  state_in    = gts_pkg::ST_P2_READ;
               end
            end
         end
         gts_pkg::ST_P2_READ: begin
            state_in = gts_pkg::ST_P2_DIFF;
         end
         gts_pkg::ST_P2_DIFF: begin
            cmd.diff_load = 1'b1;
            state_in      = gts_pkg::ST_P2_MUL;
         end
         gts_pkg::ST_P2_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.mul_last) begin
               if (status.idx_last) begin
                  state_in = gts_pkg::ST_VAR_GO;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = gts_pkg::ST_P2_READ;
               end
            end
         end
         gts_pkg::ST_VAR_GO: begin
            cmd.arith_start = 1'b1;
            cmd.arith_var   = 1'b1;
            state_in        = gts_pkg::ST_VAR_WAIT;
         end
         gts_pkg::ST_VAR_WAIT: begin
            if (status.arith_done) begin
               state_in = gts_pkg::ST_ROOT_GO;
            end
         end
         gts_pkg::ST_ROOT_GO: begin
            cmd.arith_start = 1'b1;
            cmd.arith_op    = gts_pkg::OP_SQRT;
            state_in        = gts_pkg::ST_ROOT_WAIT;
         end
         gts_pkg::ST_ROOT_WAIT: begin
            cmd.arith_op = gts_pkg::OP_SQRT;
            if (status.arith_done) begin
               cmd.dev_load = 1'b1;
               state_in     = gts_pkg::ST_OUT;
            end
         end
         gts_pkg::ST_OUT: begin
            if (!status.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = gts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gts_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/grouped_time_statistics.sv =====
// Top level of the grouped time statistics block.
//
// Sums nonzero sample times per processing unit (process and thread number) in a
// table of TABLE_DEPTH entries, and on a finish request reports count, mean,
// population standard deviation, maximum and minimum of the per-unit sums and the
// dropped flag, then empties the table. One request is handled at a time. A sample
// with zero time is ignored. Any other sample searches the table, reading and then
// comparing each entry, and inserts a new unit when no entry matches. A finish
// request on an empty table goes straight to the result. Otherwise it makes one
// walk over the units for sum, maximum and minimum, a division for the mean, a
// second walk that squares deviations with four partial products each, a division
// for the variance and a square root, the divisions and the root all in one shared
// iterative unit.
// With a single unit the second walk, the variance and the root are skipped. A
// waiting result is held in an output register while the next request is accepted;
// a finish request whose result finds that register still occupied stalls until
// the register is taken.
module grouped_time_statistics #(
   parameter int TABLE_DEPTH = gts_pkg::DEFAULT_TABLE_DEPTH,
   parameter int TIME_BITS   = gts_pkg::DEFAULT_TIME_BITS,
   parameter int SUM_BITS    = gts_pkg::DEFAULT_SUM_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gts_pkg::rsp_type rsp_data
);

   gts_pkg::cmd_type    cmd;
   gts_pkg::status_type status;

   gts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gts_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIME_BITS   (TIME_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/tb_grouped_time_statistics.sv =====
// Self-checking testbench for the grouped time statistics block.
module tb_grouped_time_statistics;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = gts_pkg::DEFAULT_TABLE_DEPTH;
   localparam logic [47:0] SUM_LIMIT = {48{1'b1}};

   // Scoreboard: keeps a software copy of the unit table and the expected results.
   class stats_scoreboard;
      logic [31:0]      keys[DEPTH];
      logic [47:0]      sums[DEPTH];
      int               used;
      bit               dropped;
      gts_pkg::rsp_type pending[$];
      int               errors;

      function void clear();
         used = 0;
         dropped = 0;
         errors = 0;
         pending.delete();
      endfunction

      // Integer square root of a 128-bit value, truncated.
      function logic [63:0] root128(logic [127:0] v);
         logic [63:0] r;
         logic [63:0] c;
         r = '0;
         for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= v) r = c;
         end
         return r;
      endfunction

      function logic [127:0] sat_add(logic [127:0] a, logic [127:0] b);
         logic [128:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[128] ? {128{1'b1}} : s[127:0];
      endfunction

      function logic [47:0] clip(logic [127:0] v);
         return (v > 128'(SUM_LIMIT)) ? SUM_LIMIT : v[47:0];
      endfunction

      // Note an accepted request and update the expected state.
      function void note_request(gts_pkg::req_type r);
         logic [31:0]      key;
         logic [127:0]     total, sq, mean, d;
         logic [47:0]      mx, mn;
         gts_pkg::rsp_type e;
         if (r.kind == gts_pkg::KIND_SAMPLE) begin
            key = {r.proc_id, r.thread_id};
            if (r.time_us == 0) return;
            for (int i = 0; i < used; i++) begin
               if (keys[i] == key) begin
                  sums[i] = clip(128'(sums[i]) + 128'(r.time_us));
                  return;
               end
            end
            if (used >= DEPTH) begin
               dropped = 1;
               return;
            end
            keys[used] = key;
            sums[used] = 48'(r.time_us);
            used++;
            return;
         end
         total = 0; sq = 0; mean = 0; mx = 0; mn = SUM_LIMIT;
         e = '0;
         if (used > 0) begin
            for (int i = 0; i < used; i++) begin
               total = sat_add(total, 128'(sums[i]));
               if (sums[i] > mx) mx = sums[i];
               if (sums[i] < mn) mn = sums[i];
            end
            mean = total / used;
            if (used > 1) begin
               for (int i = 0; i < used; i++) begin
                  d = (128'(sums[i]) >= mean) ? 128'(sums[i]) - mean : mean - 128'(sums[i]);
                  sq = sat_add(sq, d * d);
               end
               e.std_dev = clip(128'(root128(sq / used)));
            end
         end
         e.unit_count = gts_pkg::COUNT_W'(used);
         e.mean_time = clip(mean[63:0]);
         e.max_time = mx;
         e.min_time = mn;
         e.dropped_flag = dropped;
         pending = {pending, e};
         used = 0;
      endfunction

      // Compare one result with the oldest expectation.
      task check_result(gts_pkg::rsp_type got);
         gts_pkg::rsp_type e;
         if (pending.size() == 0) begin
            report("result with no expectation waiting");
            return;
         end
         e = pending.pop_front();
         if (got.unit_count !== e.unit_count) report("unit_count mismatch");
         if (got.mean_time !== e.mean_time) report("mean_time mismatch");
         if (got.std_dev !== e.std_dev) report("std_dev mismatch");
         if (got.max_time !== e.max_time) report("max_time mismatch");
         if (got.min_time !== e.min_time) report("min_time mismatch");
         if (got.dropped_flag !== e.dropped_flag) report("dropped_flag mismatch");
      endtask

      task report(string msg);
         errors++;
         $display("mismatch at %0t: %s", $time, msg);
      endtask
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   gts_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   gts_pkg::rsp_type rsp_data;

   stats_scoreboard board = new();
   bit      hold_results = 0;
   bit      random_stall = 1;

   grouped_time_statistics dut (.*);

   always #6 clock = ~clock;

   // Offer one request and wait until it is taken. Valid stays high after the
   // accepting edge until the next call or a drain replaces or drops it.
   task automatic send_request(gts_pkg::req_type r, int gap);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      board.note_request(r);
   endtask

   task automatic send_sample(logic [15:0] p, logic [15:0] t, logic [31:0] us, int gap);
      gts_pkg::req_type r;
      r.kind = gts_pkg::KIND_SAMPLE; r.proc_id = p; r.thread_id = t; r.time_us = us;
      send_request(r, gap);
   endtask

   task automatic send_finish(int gap);
      gts_pkg::req_type r;
      r = '0;
      r.kind = gts_pkg::KIND_FINISH;
      r.proc_id = 16'($urandom);
      r.thread_id = 16'($urandom);
      r.time_us = $urandom;
      send_request(r, gap);
   endtask

   // Stop offering requests until every expected result has come.
   task automatic wait_drained();
      req_valid <= 0;
      do @(posedge clock); while (board.pending.size() != 0);
   endtask

   // Result side: random stalls, with an occasional long hold-off.
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         wait_cycles = (hold_results) ? 1 : (random_stall ? $urandom_range(0, 7) : 0);
         if (wait_cycles > 0) begin
            rsp_ready <= 0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= !hold_results;
         @(posedge clock);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
      end
   end

   // Long receiver hold-off counted in its own process.
   task automatic hold_off(int cycles);
      hold_results = 1;
      repeat (cycles) @(posedge clock);
      hold_results = 0;
   endtask

   // Random set: mostly a few dozen units drawn from a small key pool.
   task automatic random_set(int count, int pool);
      int kind_pick;
      logic [31:0] us;
      for (int i = 0; i < count; i++) begin
         kind_pick = $urandom_range(0, 9);
         case (kind_pick)
            0: us = 0;
            1: us = $urandom;
            2: us = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: us = $urandom_range(1, 100000);
         endcase
         if (pool == 0)
            send_sample(16'($urandom), 16'($urandom), us, random_stall ? $urandom_range(0, 7) : 0);
         else
            send_sample(16'($urandom_range(0, pool)), 16'($urandom_range(0, 3) * 16'h5555),
                        us, random_stall ? $urandom_range(0, 7) : 0);
      end
      send_finish(random_stall ? $urandom_range(0, 7) : 0);
   endtask

   initial begin
      int sets;
      board.clear();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty set, zero time, single unit, extremes and saturation.
      send_finish(0);
      send_sample(16'h0000, 16'h0000, 32'd0, 0);
      send_finish(0);
      send_sample(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
      send_finish(0);
      send_sample(16'h0000, 16'h0000, 32'd1, 0);
      send_sample(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
      send_sample(16'hAAAA, 16'h5555, 32'hAAAA_5555, 0);
      send_sample(16'h0000, 16'h0000, 32'd5, 0);
      send_finish(0);
      // One unit given the maximum sample time repeatedly.
      for (int i = 0; i < 6; i++) send_sample(16'h1234, 16'h4321, 32'hFFFF_FFFF, 0);
      send_finish(0);

      // Fill the table while results are held back, then overflow it.
      fork
         hold_off(12000);
      join_none
      for (int i = 0; i < DEPTH + 3; i++)
         send_sample(16'(i), 16'(i * 3), 32'(i + 1), 0);
      send_sample(16'(2), 16'(6), 32'd100, 0);
      send_finish(0);
      send_finish(0);
      send_finish(0);
      wait_drained();

      // Random part: roughly 1700 requests over 85 sets.
      sets = 0;
      while (sets < 85) begin
         random_stall = (sets % 9) != 4;
         case ($urandom_range(0, 5))
            0: random_set($urandom_range(0, 3), 2);
            1: random_set($urandom_range(10, 70), 0);
            default: random_set($urandom_range(5, 30), $urandom_range(3, 40));
         endcase
         if (sets == 40) wait_drained();
         sets++;
      end
      random_stall = 1;

      wait_drained();
      repeat (1500) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Run limit, several times the slowest expected run.
   initial begin
      #100ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
